// ----- src/mlfq_pkg.sv -----
// Shared types, codes and default sizes of the multilevel feedback queue scheduler.
package mlfq_pkg;

    localparam int DEF_LEVELS      = 4;
    localparam int DEF_MAX_THREADS = 128;
    localparam int DEF_QUEUE_DEPTH = 128;

    localparam int TID_W     = 7;
    localparam int LVL_OUT_W = 2;
    localparam int TDATA_W   = 16;
    localparam int OUT_PAD_W = TDATA_W - 2 - 1 - TID_W - LVL_OUT_W;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_WAKE  = 2'd1,
        CMD_SCHED = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OUTC_TICK  = 2'd0,
        OUTC_YIELD = 2'd1,
        OUTC_EXIT  = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        Q_NOP  = 2'd0,
        Q_PUSH = 2'd1,
        Q_POP  = 2'd2
    } q_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- src/mlfq_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/mlfq_qctl.sv -----
// Queue pointer file with one shared pointer increment and address unit.
module mlfq_qctl import mlfq_pkg::*; #(
    parameter int LEVELS      = DEF_LEVELS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  q_op_t                                 op,
    input  logic [$clog2(LEVELS)-1:0]             lvl,
    output logic [$clog2(LEVELS*QUEUE_DEPTH)-1:0] addr,
    output q_stat_t                               stat,
    output logic [LEVELS-1:0]                     nonempty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QA_W  = $clog2(LEVELS * QUEUE_DEPTH);

    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];

    logic [PTR_W-1:0] ptr_sel;
    logic [PTR_W-1:0] ptr_next;
    logic [CNT_W-1:0] count_sel;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
        end
    end

    assign count_sel  = count_reg[lvl];
    assign stat.full  = (count_sel == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_sel == '0);
    assign do_push    = (op == Q_PUSH) && !stat.full;
    assign do_pop     = (op == Q_POP) && !stat.empty;

    assign ptr_sel  = (op == Q_PUSH) ? tail_reg[lvl] : head_reg[lvl];
    assign ptr_next = (ptr_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_sel + 1'b1;
    assign addr     = QA_W'(lvl) * QA_W'(QUEUE_DEPTH) + QA_W'(ptr_sel);

    always_comb
    begin
        count_next = count_sel;
        if (do_push)
        begin
            count_next = count_sel + 1'b1;
        end
        else if (do_pop)
        begin
            count_next = count_sel - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (do_push)
            begin
                tail_reg[lvl] <= ptr_next;
            end
            if (do_pop)
            begin
                head_reg[lvl] <= ptr_next;
            end
            count_reg[lvl] <= count_next;
        end
    end

endmodule

// ----- src/mlfq_thread_scheduler.sv -----
// Top level of the multilevel feedback queue thread scheduler.
//
// Commands enter on the s_axis channel, one beat per command; each command
// returns exactly one result beat on the m_axis channel.
// Add queues a thread at level 0, wake queues it at its stored level, and
// schedule retires the running head (drop, rotate or demote by outcome) and
// then reports the head of the highest-priority non-empty queue.
// A small sequencer runs each command through the queue pointer unit, the
// queue RAM and the thread level RAM, one access per cycle, in these steps:
//   add: level write, push; wake: level read, push; schedule: pop, retire,
//   push on rotate or demote, scan, head read (none if no thread is ready);
//   with no running thread, schedule starts at the scan; invalid id or
//   no-op goes straight to the result register.
// The input is not ready while a command is in flight; a new command is
// taken while a finished result still waits in the output register.
// A stalled receiver holds the result and, once the next command finishes,
// holds the sequencer until the output register frees.
// Reset empties every queue and clears the running thread; queue and level
// RAM contents are not cleared and need no clearing pass.
module mlfq_thread_scheduler import mlfq_pkg::*; #(
    parameter int LEVELS      = DEF_LEVELS,
    parameter int MAX_THREADS = DEF_MAX_THREADS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // cmd[1:0], thread_id[8:2], outcome[10:9]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata   // status_code[1:0], next_valid[2],
                                              // next_thread[9:3], next_level[11:10]
);

    localparam int LVL_W = $clog2(LEVELS);
    localparam int TL_AW = $clog2(MAX_THREADS);
    localparam int QA_W  = $clog2(LEVELS * QUEUE_DEPTH);
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LVL_RD,
        S_PUSH,
        S_POP,
        S_RETIRE,
        S_SCAN,
        S_SCAN_RD,
        S_DONE
    } state_t;

    state_t             state_reg,      state_next;
    cmd_t               cmd_reg,        cmd_next;
    logic [1:0]         outcome_reg,    outcome_next;
    logic [TID_W-1:0]   id_reg,         id_next;
    logic [LVL_W-1:0]   lvl_reg,        lvl_next;
    status_t            status_reg,     status_next;
    logic               found_reg,      found_next;
    logic               run_valid_reg,  run_valid_next;
    logic [LVL_W-1:0]   run_lvl_reg,    run_lvl_next;
    logic               out_valid_reg,  out_valid_next;
    logic [TDATA_W-1:0] out_data_reg,   out_data_next;

    cmd_t             in_cmd;
    logic [TID_W-1:0] in_tid;
    logic [1:0]       in_outcome;
    logic             in_tid_ok;
    logic             ret_tid_ok;

    q_op_t             q_op;
    logic [LVL_W-1:0]  q_lvl;
    logic [QA_W-1:0]   q_addr;
    q_stat_t           q_stat;
    logic [LEVELS-1:0] q_nonempty;
    logic              qram_we;
    logic [TID_W-1:0]  q_rdata;

    logic              tl_we;
    logic [TL_AW-1:0]  tl_addr;
    logic [LVL_W-1:0]  tl_wdata;
    logic [LVL_W-1:0]  tl_rdata;

    logic              scan_hit;
    logic [LVL_W-1:0]  scan_lvl;
    logic [TDATA_W-1:0] out_pack;

    assign in_cmd     = cmd_t'(s_axis_tdata[1:0]);
    assign in_tid     = s_axis_tdata[8:2];
    assign in_outcome = s_axis_tdata[10:9];
    assign in_tid_ok  = (32'(in_tid) < 32'(MAX_THREADS));
    assign ret_tid_ok = (32'(q_rdata) < 32'(MAX_THREADS));

    mlfq_qctl #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_qctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (q_op),
        .lvl      (q_lvl),
        .addr     (q_addr),
        .stat     (q_stat),
        .nonempty (q_nonempty)
    );

    mlfq_ram #(
        .WIDTH (TID_W),
        .DEPTH (LEVELS * QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (qram_we),
        .waddr (q_addr),
        .wdata (id_reg),
        .raddr (q_addr),
        .rdata (q_rdata)
    );

    mlfq_ram #(
        .WIDTH (LVL_W),
        .DEPTH (MAX_THREADS)
    ) u_level_ram (
        .clk   (clk),
        .we    (tl_we),
        .waddr (tl_addr),
        .wdata (tl_wdata),
        .raddr (tl_addr),
        .rdata (tl_rdata)
    );

    always_comb
    begin
        scan_hit = 1'b0;
        scan_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (q_nonempty[i])
            begin
                scan_hit = 1'b1;
                scan_lvl = LVL_W'(i);
            end
        end
    end

    assign out_pack = {OUT_PAD_W'(0),
                       found_reg ? LVL_OUT_W'(lvl_reg) : LVL_OUT_W'(0),
                       found_reg ? id_reg : TID_W'(0),
                       found_reg,
                       status_reg};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        outcome_next   = outcome_reg;
        id_next        = id_reg;
        lvl_next       = lvl_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        run_valid_next = run_valid_reg;
        run_lvl_next   = run_lvl_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_op           = Q_NOP;
        q_lvl          = lvl_reg;
        qram_we        = 1'b0;
        tl_we          = 1'b0;
        tl_addr        = TL_AW'(in_tid);
        tl_wdata       = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next     = in_cmd;
                    id_next      = in_tid;
                    outcome_next = in_outcome;
                    status_next  = ST_OK;
                    found_next   = 1'b0;
                    lvl_next     = '0;
                    case (in_cmd)
                        CMD_ADD:
                        begin
                            if (in_tid_ok)
                            begin
                                tl_we      = 1'b1;
                                state_next = S_PUSH;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        CMD_WAKE:
                        begin
                            state_next = in_tid_ok ? S_LVL_RD : S_DONE;
                        end
                        CMD_SCHED:
                        begin
                            q_lvl = run_lvl_reg;
                            if (run_valid_reg && !q_stat.empty)
                            begin
                                lvl_next   = run_lvl_reg;
                                state_next = S_POP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_LVL_RD:
            begin
                lvl_next   = (32'(tl_rdata) >= 32'(LEVELS)) ? LAST_LVL : tl_rdata;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (q_stat.full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    q_op    = Q_PUSH;
                    qram_we = 1'b1;
                end
                state_next = (cmd_reg == CMD_SCHED) ? S_SCAN : S_DONE;
            end
            S_POP:
            begin
                q_op       = Q_POP;
                state_next = S_RETIRE;
            end
            S_RETIRE:
            begin
                id_next = q_rdata;
                if (outcome_reg >= 2'(OUTC_EXIT))
                begin
                    state_next = S_SCAN;
                end
                else if (outcome_reg == 2'(OUTC_YIELD) || lvl_reg == LAST_LVL)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                    if (ret_tid_ok)
                    begin
                        tl_we    = 1'b1;
                        tl_addr  = TL_AW'(q_rdata);
                        tl_wdata = lvl_reg + 1'b1;
                    end
                    state_next = S_PUSH;
                end
            end
            S_SCAN:
            begin
                q_lvl = scan_lvl;
                if (scan_hit)
                begin
                    run_valid_next = 1'b1;
                    run_lvl_next   = scan_lvl;
                    lvl_next       = scan_lvl;
                    found_next     = 1'b1;
                    state_next     = S_SCAN_RD;
                end
                else
                begin
                    run_valid_next = 1'b0;
                    if (status_reg == ST_OK)
                    begin
                        status_next = ST_NONE;
                    end
                    state_next = S_DONE;
                end
            end
            S_SCAN_RD:
            begin
                id_next    = q_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = out_pack;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_NOP;
            outcome_reg   <= '0;
            id_reg        <= '0;
            lvl_reg       <= '0;
            status_reg    <= ST_OK;
            found_reg     <= 1'b0;
            run_valid_reg <= 1'b0;
            run_lvl_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            outcome_reg   <= outcome_next;
            id_reg        <= id_next;
            lvl_reg       <= lvl_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            run_valid_reg <= run_valid_next;
            run_lvl_reg   <= run_lvl_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- src/mlfq_chk.sv -----
// Port-level checker for the scheduler and its bind to the top level.
module mlfq_chk import mlfq_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [TDATA_W-1:0] s_axis_tdata,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[TDATA_W-1:3] == '0)
        else $error("result without a thread carries a thread or level");

    a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'(ST_OK)
                                          || m_axis_tdata[1:0] == 2'(ST_FULL))
        else $error("selected thread reported with a bad status");

endmodule

bind mlfq_thread_scheduler mlfq_chk u_mlfq_chk (.*);

// ----- tb/sv/mlfq_thread_scheduler_tb.sv -----
// Self-checking testbench for the multilevel feedback queue thread scheduler.
module mlfq_thread_scheduler_tb;
    import mlfq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS          = DEF_LEVELS;
    localparam int MAX_THREADS     = DEF_MAX_THREADS;
    localparam int QUEUE_DEPTH     = DEF_QUEUE_DEPTH;
    localparam int RANDOM_ITEMS    = 170;
    localparam int PRESSURE_AT     = 150;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [1:0] OUTC_RESERVED = 2'd3;

    typedef struct packed {
        status_t                status;
        logic                   valid;
        logic [TID_W-1:0]       thread;
        logic [LVL_OUT_W-1:0]   level;
    } sched_result_t;

    class sched_scoreboard;
        logic [TID_W-1:0]     ready_q[LEVELS][$];
        logic [LVL_OUT_W-1:0] thread_lvl[MAX_THREADS];
        bit                   known[MAX_THREADS];
        bit                   running;
        int                   run_lvl;
        sched_result_t        expected[$];
        int                   errors;
        int                   results_seen;

        function new();
            running      = 1'b0;
            run_lvl      = 0;
            errors       = 0;
            results_seen = 0;
            foreach (known[i])
                known[i] = 1'b0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function int pick_known(int want_lvl);
            int cand[$];
            foreach (known[i])
                if (known[i] && (want_lvl < 0 || int'(thread_lvl[i]) == want_lvl))
                    cand.push_back(i);
            if (cand.size() == 0)
                return -1;
            return cand[$urandom_range(0, cand.size() - 1)];
        endfunction

        function void note_command(cmd_t c, logic [TID_W-1:0] tid, logic [1:0] outc);
            sched_result_t    r;
            int               lvl;
            logic [TID_W-1:0] id;
            r = '0;
            case (c)
                CMD_ADD, CMD_WAKE:
                begin
                    if (c == CMD_ADD)
                    begin
                        thread_lvl[tid] = '0;
                        known[tid]      = 1'b1;
                        lvl             = 0;
                    end
                    else
                        lvl = int'(thread_lvl[tid]);
                    if (ready_q[lvl].size() >= QUEUE_DEPTH)
                        r.status = ST_FULL;
                    else
                        ready_q[lvl].push_back(tid);
                end
                CMD_SCHED:
                begin
                    if (running && ready_q[run_lvl].size() != 0)
                    begin
                        id = ready_q[run_lvl].pop_front();
                        if (outc >= OUTC_EXIT)
                            ;
                        else if (outc == OUTC_YIELD || run_lvl == LEVELS - 1)
                            ready_q[run_lvl].push_back(id);
                        else
                        begin
                            thread_lvl[id] = LVL_OUT_W'(run_lvl + 1);
                            if (ready_q[run_lvl + 1].size() >= QUEUE_DEPTH)
                                r.status = ST_FULL;
                            else
                                ready_q[run_lvl + 1].push_back(id);
                        end
                    end
                    running = 1'b0;
                    for (int l = 0; l < LEVELS; l++)
                    begin
                        if (!running && ready_q[l].size() != 0)
                        begin
                            running  = 1'b1;
                            run_lvl  = l;
                            r.valid  = 1'b1;
                            r.thread = ready_q[l][0];
                            r.level  = LVL_OUT_W'(l);
                        end
                    end
                    if (!running && r.status == ST_OK)
                        r.status = ST_NONE;
                end
                default:
                    ;
            endcase
            expected.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                flag_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                        results_seen, name, got, want));
        endtask

        task check_result(logic [TDATA_W-1:0] d);
            sched_result_t want;
            if (expected.size() == 0)
            begin
                flag_mismatch($sformatf("result beat %h with no command pending", d));
                return;
            end
            want = expected.pop_front();
            compare_field("status_code", int'(d[1:0]), int'(want.status));
            compare_field("next_valid", int'(d[2]), int'(want.valid));
            compare_field("next_thread", int'(d[9:3]), int'(want.thread));
            compare_field("next_level", int'(d[11:10]), int'(want.level));
            results_seen++;
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;

    sched_scoreboard sb = new();

    bit quiet;
    bit hold_off_req;
    int n_sent;
    int stall_cycles;

    mlfq_thread_scheduler #(
        .LEVELS      (LEVELS),
        .MAX_THREADS (MAX_THREADS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sink side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            else if (hold_left == 0 && !quiet && $urandom_range(0, 11) == 0)
                hold_left = $urandom_range(1, 16);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_command(cmd_t c, logic [TID_W-1:0] tid, logic [1:0] outc);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, outc, tid, c};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_command(c, tid, outc);
        n_sent++;
        @(negedge clk);
    endtask

    function automatic logic [1:0] pick_outcome();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OUTC_TICK;
        if (r < 65)
            return OUTC_YIELD;
        if (r < 90)
            return OUTC_EXIT;
        return OUTC_RESERVED;
    endfunction

    task automatic send_wake(int want_lvl);
        int id;
        id = sb.pick_known(want_lvl);
        if (id < 0)
            send_command(CMD_ADD, TID_W'($urandom_range(0, MAX_THREADS - 1)),
                         2'($urandom_range(0, 3)));
        else
            send_command(CMD_WAKE, TID_W'(id), 2'($urandom_range(0, 3)));
    endtask

    task automatic send_random(int w_add, int w_wake);
        int               pick;
        logic [TID_W-1:0] tid;
        tid  = TID_W'($urandom_range(0, MAX_THREADS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 3)
            send_command(CMD_NOP, tid, 2'($urandom_range(0, 3)));
        else if (pick < 3 + w_add)
            send_command(CMD_ADD, tid, 2'($urandom_range(0, 3)));
        else if (pick < 3 + w_add + w_wake)
            send_wake(-1);
        else
            send_command(CMD_SCHED, tid, pick_outcome());
    endtask

    initial
    begin
        int  seg_len;
        int  mode;
        bit  pressured;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        hold_off_req  = 1'b0;
        n_sent        = 0;
        stall_cycles  = 0;
        pressured     = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk one thread down every level, then rotate, yield, drop and rewake.
        send_command(CMD_SCHED, 7'h00, OUTC_TICK);
        send_command(CMD_ADD, 7'h7F, OUTC_TICK);
        send_command(CMD_SCHED, 7'h00, OUTC_TICK);
        send_command(CMD_SCHED, 7'h7F, OUTC_TICK);
        send_command(CMD_SCHED, 7'h00, OUTC_TICK);
        send_command(CMD_SCHED, 7'h7F, OUTC_TICK);
        send_command(CMD_SCHED, 7'h00, OUTC_TICK);
        send_command(CMD_SCHED, 7'h7F, OUTC_YIELD);
        send_command(CMD_SCHED, 7'h00, OUTC_EXIT);
        send_command(CMD_WAKE, 7'h7F, OUTC_TICK);
        send_command(CMD_ADD, 7'h00, OUTC_TICK);
        send_command(CMD_SCHED, 7'h2A, OUTC_RESERVED);
        send_command(CMD_SCHED, 7'h55, OUTC_TICK);
        send_command(CMD_SCHED, 7'h00, OUTC_RESERVED);
        send_command(CMD_ADD, 7'h55, OUTC_RESERVED);
        send_command(CMD_WAKE, 7'h55, OUTC_YIELD);
        send_command(CMD_SCHED, 7'h00, OUTC_YIELD);
        send_command(CMD_NOP, 7'h2A, OUTC_YIELD);
        send_command(CMD_NOP, 7'h55, OUTC_RESERVED);
        send_command(CMD_SCHED, 7'h7F, OUTC_EXIT);
        send_command(CMD_SCHED, 7'h00, OUTC_EXIT);

        // Random segments: balanced, filling and draining mixes.
        while (n_sent < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(10, 50);
            mode    = $urandom_range(0, 2);
            repeat (seg_len)
            begin
                if (!pressured && n_sent >= PRESSURE_AT)
                begin
                    hold_off_req = 1'b1;
                    pressured    = 1'b1;
                end
                case (mode)
                    0: send_random(25, 20);
                    1: send_random(45, 30);
                    default: send_random(10, 10);
                endcase
            end
        end

        // Overfill level 0, demote a few, overfill level 1 by wakes, then
        // demote into the full level.
        repeat (QUEUE_DEPTH + 2)
            send_command(CMD_ADD, TID_W'($urandom_range(0, MAX_THREADS - 1)),
                         2'($urandom_range(0, 3)));
        repeat (8)
            send_command(CMD_SCHED, TID_W'($urandom_range(0, MAX_THREADS - 1)), OUTC_TICK);
        repeat (QUEUE_DEPTH + 2)
            send_wake(1);
        repeat (4)
            send_command(CMD_SCHED, TID_W'($urandom_range(0, MAX_THREADS - 1)), OUTC_TICK);

        quiet = 1'b1;
        repeat (40)
            send_random(15, 15);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
